### src/shared_memory_double_stack_defines.svh
// Assertion macros shared by the shared-memory double stack RTL.
`ifndef SHARED_MEMORY_DOUBLE_STACK_DEFINES_SVH
`define SHARED_MEMORY_DOUBLE_STACK_DEFINES_SVH

// Checks a condition at every clock edge outside reset.
`define SMS_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that a trigger is followed by a condition in the next cycle.
`define SMS_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) else $error(msg);

`endif

### src/sms_pkg.sv
// Types and constants shared by the shared-memory double stack modules.
`default_nettype none

package sms_pkg;

	localparam int CAP_W   = 9;
	localparam int OPND_W  = 32;
	localparam int FOUND_W = 8;

	typedef enum logic [2:0] {
		CMD_PUSH_A = 3'd0,
		CMD_PUSH_B = 3'd1,
		CMD_POP_A  = 3'd2,
		CMD_POP_B  = 3'd3,
		CMD_PEEK_A = 3'd4,
		CMD_PEEK_B = 3'd5,
		CMD_CLEAR  = 3'd6,
		CMD_SEARCH = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_FULL     = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic             wr;
		logic [CAP_W-1:0] capacity;
	} cfg_t;

endpackage

`default_nettype wire

### src/shared_memory_double_stack.sv
// Top level: two stacks sharing one word store, with an APB capacity register.
// Push, clear and failed pop or peek: result beat on the next cycle, busy stays low,
// so one such item per cycle. Pop and peek: busy high for one cycle for the store read,
// result beat from the read state; no new command until idle again. Search walks one entry
// per cycle up to the first match or the last entry below capacity. The receiver cannot
// stall. After reset a clearing pass zeroes the whole store with busy high.
`default_nettype none

module shared_memory_double_stack #(
	parameter int STORE_DEPTH = 256,
	parameter int WORD_WIDTH  = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         cmd,
	input  wire logic signed [31:0] operand_value,
	output logic                    done,
	output logic        [1:0]       status,
	output logic signed [31:0]      result_value,
	output logic        [7:0]       found_index,
	output logic        [8:0]       count_a,
	output logic        [8:0]       count_b,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic   [1:0]       paddr,
	input  wire logic   [31:0]      pwdata,
	output logic        [31:0]      prdata,
	output logic                    pready
);
	import sms_pkg::*;

	localparam int ADDR_W = $clog2(STORE_DEPTH);

	cfg_t                  cfg;
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr;
	logic [WORD_WIDTH-1:0] mem_wdata;
	logic [ADDR_W-1:0]     mem_raddr;
	logic [WORD_WIDTH-1:0] mem_rdata;

	sms_cfg #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	sms_mem #(
		.DEPTH (STORE_DEPTH),
		.WIDTH (WORD_WIDTH),
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	sms_ctrl #(
		.STORE_DEPTH(STORE_DEPTH),
		.WORD_WIDTH (WORD_WIDTH),
		.ADDR_W     (ADDR_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd_t'(cmd)),
		.operand_value(operand_value),
		.cfg          (cfg),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.busy         (busy),
		.done         (done),
		.status       (status),
		.result_value (result_value),
		.found_index  (found_index),
		.count_a      (count_a),
		.count_b      (count_b)
	);

endmodule

`default_nettype wire

### src/sms_mem.sv
// Word store: one write port and one registered read port.
`default_nettype none

module sms_mem #(
	parameter int DEPTH  = 256,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 8
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### src/sms_cfg.sv
// APB register block holding the shared capacity register.
`default_nettype none

module sms_cfg #(
	parameter int STORE_DEPTH = 256
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [1:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	output sms_pkg::cfg_t     cfg
);
	import sms_pkg::*;

	localparam int CAP_LIM = (STORE_DEPTH < 511) ? STORE_DEPTH : 511;
	localparam int CAP_RST = (STORE_DEPTH < 256) ? STORE_DEPTH : 256;

	logic [CAP_W-1:0] cap_q;
	logic [CAP_W-1:0] wval;
	logic [CAP_W-1:0] wval_clamped;
	logic             wr;
	logic             unused_addr;

	assign wr          = psel & penable & pwrite;
	assign wval        = pwdata[CAP_W-1:0];
	assign unused_addr = ^paddr;

	always_comb begin
		priority if (wval == '0) begin
			wval_clamped = CAP_W'(1);
		end else if (wval > CAP_W'(CAP_LIM)) begin
			wval_clamped = CAP_W'(CAP_LIM);
		end else begin
			wval_clamped = wval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(CAP_RST);
		end else if (wr) begin
			cap_q <= wval_clamped;
		end
	end

	assign prdata       = 32'(cap_q) | 32'(unused_addr & 1'b0);
	assign pready       = 1'b1;
	assign cfg.wr       = wr;
	assign cfg.capacity = cap_q;

endmodule

`default_nettype wire

### src/sms_ctrl.sv
// Command sequencer: stack pointers, store access, search walk and clearing pass.
`default_nettype none
`include "shared_memory_double_stack_defines.svh"

module sms_ctrl #(
	parameter int STORE_DEPTH = 256,
	parameter int WORD_WIDTH  = 32,
	parameter int ADDR_W      = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire sms_pkg::cmd_t             cmd,
	input  wire logic signed [31:0]        operand_value,
	input  wire sms_pkg::cfg_t             cfg,
	output logic                           mem_we,
	output logic        [ADDR_W-1:0]       mem_waddr,
	output logic        [WORD_WIDTH-1:0]   mem_wdata,
	output logic        [ADDR_W-1:0]       mem_raddr,
	input  wire logic   [WORD_WIDTH-1:0]   mem_rdata,
	output logic                           busy,
	output logic                           done,
	output logic        [1:0]              status,
	output logic signed [31:0]             result_value,
	output logic        [7:0]              found_index,
	output logic        [8:0]              count_a,
	output logic        [8:0]              count_b
);
	import sms_pkg::*;

	typedef enum logic [1:0] {
		S_CLR,
		S_IDLE,
		S_READ,
		S_SCAN
	} state_t;

	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_DEPTH - 1);

	state_t                  state_q;
	logic [ADDR_W-1:0]       clr_q;
	logic [CAP_W-1:0]        depth_a_q;
	logic [CAP_W-1:0]        depth_b_q;
	logic [CAP_W-1:0]        idx_q;
	logic [WORD_WIDTH-1:0]   key_q;
	logic                    done_q;
	status_t                 status_q;
	logic [OPND_W-1:0]       result_q;
	logic [FOUND_W-1:0]      found_q;

	logic [CAP_W-1:0]        cap;
	logic [CAP_W:0]          depth_sum;
	logic [CAP_W:0]          idx_next;
	logic                    full;
	logic                    accept;
	logic                    push_ok;
	logic [WORD_WIDTH-1:0]   word;
	logic [CAP_W-1:0]        wr_idx;
	logic [CAP_W-1:0]        rd_idx;

	assign cap       = cfg.capacity;
	assign depth_sum = {1'b0, depth_a_q} + {1'b0, depth_b_q};
	assign full      = depth_sum >= {1'b0, cap};
	assign idx_next  = {1'b0, idx_q} + (CAP_W+1)'(1);
	assign accept    = start && (state_q == S_IDLE);
	assign push_ok   = accept && !full && (cmd == CMD_PUSH_A || cmd == CMD_PUSH_B);
	assign word      = WORD_WIDTH'($unsigned(operand_value));

	always_comb begin
		if (cmd == CMD_PUSH_B) begin
			wr_idx = cap - CAP_W'(1) - depth_b_q;
		end else begin
			wr_idx = depth_a_q;
		end
	end

	always_comb begin
		priority if (state_q == S_SCAN) begin
			rd_idx = idx_next[CAP_W-1:0];
		end else if (cmd == CMD_SEARCH) begin
			rd_idx = '0;
		end else if (cmd == CMD_POP_B || cmd == CMD_PEEK_B) begin
			rd_idx = cap - depth_b_q;
		end else begin
			rd_idx = depth_a_q - CAP_W'(1);
		end
	end

	always_comb begin
		if (state_q == S_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = push_ok;
			mem_waddr = ADDR_W'(wr_idx);
			mem_wdata = word;
		end
	end

	assign mem_raddr = ADDR_W'(rd_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			depth_a_q <= '0;
			depth_b_q <= '0;
			idx_q     <= '0;
			key_q     <= '0;
			done_q    <= 1'b0;
			status_q  <= STAT_OK;
			result_q  <= '0;
			found_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						done_q   <= 1'b1;
						status_q <= STAT_OK;
						result_q <= '0;
						found_q  <= '0;
						unique case (cmd)
							CMD_PUSH_A: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									depth_a_q <= depth_a_q + CAP_W'(1);
								end
							end
							CMD_PUSH_B: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									depth_b_q <= depth_b_q + CAP_W'(1);
								end
							end
							CMD_POP_A, CMD_PEEK_A: begin
								if (depth_a_q == '0) begin
									status_q <= STAT_EMPTY;
								end else begin
									done_q  <= 1'b0;
									state_q <= S_READ;
									if (cmd == CMD_POP_A) begin
										depth_a_q <= depth_a_q - CAP_W'(1);
									end
								end
							end
							CMD_POP_B, CMD_PEEK_B: begin
								if (depth_b_q == '0) begin
									status_q <= STAT_EMPTY;
								end else begin
									done_q  <= 1'b0;
									state_q <= S_READ;
									if (cmd == CMD_POP_B) begin
										depth_b_q <= depth_b_q - CAP_W'(1);
									end
								end
							end
							CMD_CLEAR: begin
								depth_a_q <= '0;
								depth_b_q <= '0;
							end
							CMD_SEARCH: begin
								done_q  <= 1'b0;
								idx_q   <= '0;
								key_q   <= word;
								state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_READ: begin
					done_q   <= 1'b1;
					result_q <= OPND_W'(mem_rdata);
					state_q  <= S_IDLE;
				end
				S_SCAN: begin
					priority if (mem_rdata == key_q) begin
						done_q   <= 1'b1;
						status_q <= STAT_OK;
						found_q  <= idx_q[FOUND_W-1:0];
						state_q  <= S_IDLE;
					end else if (idx_next >= {1'b0, cap}) begin
						done_q   <= 1'b1;
						status_q <= STAT_NOTFOUND;
						state_q  <= S_IDLE;
					end else begin
						idx_q <= idx_next[CAP_W-1:0];
					end
				end
			endcase
			if (cfg.wr) begin
				depth_a_q <= '0;
				depth_b_q <= '0;
			end
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign result_value = result_q;
	assign found_index  = found_q;
	assign count_a      = depth_a_q;
	assign count_b      = depth_b_q;

	`SMS_ASSERT(a_depth_bound, depth_sum <= {1'b0, cap}, "Stack depths exceed the capacity.")
	`SMS_ASSERT(a_done_idle, !done_q || state_q == S_IDLE, "Result beat while the block is busy.")
	`SMS_ASSERT_NEXT(a_push_done, push_ok, done_q && status_q == STAT_OK, "Push gave no result.")
	`SMS_ASSERT_NEXT(a_clr_exit, state_q == S_CLR && clr_q == CLR_LAST, state_q == S_IDLE, "Clearing pass overran.")

endmodule

`default_nettype wire

### dv/sms_tb_pkg.sv
// Scoreboard class for the shared-memory double stack: predicts each reply and checks it.
package sms_tb_pkg;

	import sms_pkg::*;

	typedef struct {
		status_t     status;
		logic [31:0] value;
		logic [7:0]  index;
		logic [8:0]  cnt_a;
		logic [8:0]  cnt_b;
	} stack_reply_t;

	class stack_checker;
		logic [31:0]  words[256];
		int           depth_a;
		int           depth_b;
		int           cap;
		int           errors;
		stack_reply_t pending_replies[$];

		function new();
			foreach (words[i]) words[i] = '0;
			depth_a = 0;
			depth_b = 0;
			cap = 256;
			errors = 0;
		endfunction

		function void set_capacity(logic [31:0] data);
			int v;
			v = int'(data[8:0]);
			if (v < 1) v = 1;
			if (v > 256) v = 256;
			cap = v;
			depth_a = 0;
			depth_b = 0;
		endfunction

		function void note_command(logic [2:0] code, logic [31:0] operand);
			stack_reply_t r;
			bit full;
			r.status = STAT_OK;
			r.value = '0;
			r.index = '0;
			full = (depth_a + depth_b) >= cap;
			case (cmd_t'(code))
				CMD_PUSH_A: begin
					if (full) r.status = STAT_FULL;
					else begin
						words[depth_a] = operand;
						depth_a++;
					end
				end
				CMD_PUSH_B: begin
					if (full) r.status = STAT_FULL;
					else begin
						words[cap - 1 - depth_b] = operand;
						depth_b++;
					end
				end
				CMD_POP_A, CMD_PEEK_A: begin
					if (depth_a == 0) r.status = STAT_EMPTY;
					else begin
						r.value = words[depth_a - 1];
						if (cmd_t'(code) == CMD_POP_A) depth_a--;
					end
				end
				CMD_POP_B, CMD_PEEK_B: begin
					if (depth_b == 0) r.status = STAT_EMPTY;
					else begin
						r.value = words[cap - depth_b];
						if (cmd_t'(code) == CMD_POP_B) depth_b--;
					end
				end
				CMD_CLEAR: begin
					depth_a = 0;
					depth_b = 0;
				end
				default: begin
					r.status = STAT_NOTFOUND;
					for (int i = 0; i < cap; i++) begin
						if (words[i] == operand) begin
							r.status = STAT_OK;
							r.index = i[7:0];
							break;
						end
					end
				end
			endcase
			r.cnt_a = depth_a[8:0];
			r.cnt_b = depth_b[8:0];
			pending_replies.push_back(r);
		endfunction

		function void check_reply(logic [1:0] status, logic [31:0] value, logic [7:0] index,
				logic [8:0] cnt_a, logic [8:0] cnt_b);
			stack_reply_t e;
			if (pending_replies.size() == 0) begin
				$error("result beat with no command outstanding");
				errors++;
				return;
			end
			e = pending_replies.pop_front();
			if (status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, status);
				errors++;
			end
			if (value !== e.value) begin
				$error("result_value: expected %h, got %h", e.value, value);
				errors++;
			end
			if (index !== e.index) begin
				$error("found_index: expected %0d, got %0d", e.index, index);
				errors++;
			end
			if (cnt_a !== e.cnt_a) begin
				$error("count_a: expected %0d, got %0d", e.cnt_a, cnt_a);
				errors++;
			end
			if (cnt_b !== e.cnt_b) begin
				$error("count_b: expected %0d, got %0d", e.cnt_b, cnt_b);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_replies.size();
		endfunction
	endclass

endpackage

### dv/tb_top.sv
// Top-level testbench for the shared-memory double stack: directed and random command beats.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sms_pkg::*;
	import sms_tb_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam logic [1:0] CAPACITY_ADDR = 2'd0;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  cmd;
	logic [31:0] operand_value;
	logic        done;
	logic [1:0]  status;
	logic [31:0] result_value;
	logic [7:0]  found_index;
	logic [8:0]  count_a;
	logic [8:0]  count_b;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	stack_checker stacks = new();
	logic [31:0]  recent_words[$];
	int           idle_cycles = 0;

	shared_memory_double_stack DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.operand_value(operand_value),
		.done(done),
		.status(status),
		.result_value(result_value),
		.found_index(found_index),
		.count_a(count_a),
		.count_b(count_b),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == CAPACITY_ADDR)
				stacks.set_capacity(pwdata);
			if (done)
				stacks.check_reply(status, result_value, found_index, count_a, count_b);
			if (start && !busy)
				stacks.note_command(cmd, operand_value);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("shared_memory_double_stack verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic issue(cmd_t code, logic [31:0] operand, int gap);
		start <= 1'b1;
		cmd <= code;
		operand_value <= operand;
		do @(posedge clk); while (busy);
		if (code == CMD_PUSH_A || code == CMD_PUSH_B) begin
			recent_words.push_back(operand);
			if (recent_words.size() > 32) void'(recent_words.pop_front());
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (stacks.outstanding() != 0 || busy) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_capacity(logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAPACITY_ADDR;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h7FFF_FFFF;
					default: return 32'h8000_0000;
				endcase
			end
			1: return $urandom_range(0, 15);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] search_key();
		if (recent_words.size() != 0 && $urandom_range(0, 1) == 1)
			return recent_words[$urandom_range(0, recent_words.size() - 1)];
		return pick_word();
	endfunction

	task automatic random_phase(int items);
		int push_bias;
		bit burst;
		int r;
		int gap;
		cmd_t code;
		logic [31:0] word;
		push_bias = $urandom_range(20, 80);
		burst = ($urandom_range(0, 2) == 0);
		for (int n = 0; n < items; n++) begin
			r = $urandom_range(0, 99);
			if (r < 4) code = CMD_CLEAR;
			else if (r < 12) code = CMD_SEARCH;
			else if (r < 12 + push_bias * 88 / 100)
				code = ($urandom_range(0, 1) == 1) ? CMD_PUSH_B : CMD_PUSH_A;
			else code = cmd_t'($urandom_range(2, 5));
			word = (code == CMD_SEARCH) ? search_key() : pick_word();
			gap = burst ? 0 : $urandom_range(0, 17);
			issue(code, word, gap);
		end
	endtask

	initial begin
		logic [31:0] caps[12];
		logic [31:0] data;
		caps = '{32'd0, 32'd511, 32'd2, 32'd256, 32'd17, 32'd3, 32'd64, 32'd0,
			32'd300, 32'd128, 32'd5, 32'd200};
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_PUSH_A;
		operand_value <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= CAPACITY_ADDR;
		pwdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(CMD_SEARCH, 32'h0000_0000, 0);
		issue(CMD_POP_A, 32'hFFFF_FFFF, 1);
		issue(CMD_POP_B, 32'h0000_0000, 0);
		issue(CMD_PEEK_A, 32'h0000_0000, 3);
		issue(CMD_PEEK_B, 32'h0000_0000, 0);
		issue(CMD_PUSH_A, 32'h7FFF_FFFF, 0);
		issue(CMD_PUSH_A, 32'h8000_0000, 2);
		issue(CMD_PUSH_B, 32'hFFFF_FFFF, 0);
		issue(CMD_PUSH_B, 32'h0000_0001, 0);
		issue(CMD_PEEK_A, 32'h0000_0000, 0);
		issue(CMD_PEEK_B, 32'h0000_0000, 1);
		issue(CMD_SEARCH, 32'h8000_0000, 0);
		issue(CMD_SEARCH, 32'h1234_5678, 0);
		issue(CMD_POP_A, 32'h0000_0000, 0);
		issue(CMD_POP_B, 32'h0000_0000, 0);
		issue(CMD_CLEAR, 32'h0000_0000, 0);
		issue(CMD_SEARCH, 32'hFFFF_FFFF, 0);
		issue(CMD_POP_A, 32'h0000_0000, 0);
		drain();
		write_capacity(32'd1);
		issue(CMD_PUSH_A, 32'hA5A5_5A5A, 0);
		issue(CMD_PUSH_B, 32'h0000_0003, 0);
		issue(CMD_PUSH_A, 32'h0000_0004, 0);
		issue(CMD_POP_A, 32'h0000_0000, 0);
		issue(CMD_PUSH_B, 32'hC3C3_3C3C, 0);
		issue(CMD_PEEK_B, 32'h0000_0000, 0);
		issue(CMD_POP_B, 32'h0000_0000, 0);

		for (int k = 0; k < 12; k++) begin
			drain();
			data = (k == 7) ? $urandom() : caps[k];
			write_capacity(data);
			random_phase(70);
		end

		drain();
		repeat (260) @(posedge clk);
		if (stacks.errors == 0 && stacks.outstanding() == 0) begin
			$display("shared_memory_double_stack verification clean");
		end else begin
			$display("shared_memory_double_stack verification failed");
		end
		$finish;
	end

endmodule

### files.f
+incdir+src
src/sms_pkg.sv
src/sms_mem.sv
src/sms_cfg.sv
src/sms_ctrl.sv
src/shared_memory_double_stack.sv
dv/sms_tb_pkg.sv
dv/tb_top.sv
